// File: hw/rtl/irpwe_pkg.sv
package irpwe_pkg;

   localparam int DefMaxDataBits = 9;
   localparam int BitCntW        = 4;   // kind bit counts never exceed 9
   localparam int QueueDepth     = 2;

   localparam logic [15:0] PresyncOnUs  = 16'd3000;
   localparam logic [15:0] PresyncOffUs = 16'd6000;
   localparam logic [15:0] HdrShortUs   = 16'd3000;
   localparam logic [15:0] HdrLongUs    = 16'd6000;
   localparam logic [15:0] GapOffUs     = 16'd2000;
   localparam logic [15:0] BitZeroUs    = 16'd1000;
   localparam logic [15:0] BitOneUs     = 16'd2000;
   localparam logic [15:0] IdleDefHalf  = 16'(25000 / 2);
   localparam logic [15:0] IdleTagHalf  = 16'(56000 / 2);
   localparam logic [15:0] IdleCsumHalf = 16'(80000 / 2);
   localparam logic [8:0]  CsumFlag     = 9'(256);

   typedef enum logic [2:0] {
      CMD_TAG    = 3'd0,
      CMD_BEACON = 3'd1,
      CMD_LBEACON = 3'd2,
      CMD_PACKET = 3'd3,
      CMD_DATA   = 3'd4,
      CMD_CSUM   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRESYNC,
      ST_HEADER,
      ST_BITS,
      ST_GAP,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [8:0] payload;
   } req_type;

   typedef struct packed {
      logic        mark_level;
      logic [15:0] mark_us;
      logic [15:0] space_us;
      logic        last_item;
   } rsp_type;

   // one classified request, ready for the sequencer
   typedef struct packed {
      logic               header_long;
      logic               term;
      logic [BitCntW-1:0] nbits;
      logic [8:0]         word;
      logic [15:0]        gap_half_us;
   } job_type;

endpackage

// File: hw/rtl/irpwe_front.sv
module irpwe_front
   import irpwe_pkg::*;
#(
   parameter int MAX_DATA_BITS = DefMaxDataBits
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    job_valid,
   output job_type job
);

   logic [7:0]         sum_ff, sum_in;
   logic [BitCntW-1:0] kind_bits;

   always_comb begin
      job       = '0;
      job_valid = 1'b0;
      sum_in    = sum_ff;
      kind_bits = '0;
      job.word  = req.payload;
      unique case (req.command)
         CMD_TAG: begin
            job_valid = 1'b1; kind_bits = BitCntW'(7);
            job.term = 1'b1; job.gap_half_us = IdleTagHalf;
         end
         CMD_BEACON: begin
            job_valid = 1'b1; kind_bits = BitCntW'(5); job.header_long = 1'b1;
            job.term = 1'b1; job.gap_half_us = IdleDefHalf;
         end
         CMD_LBEACON: begin
            job_valid = 1'b1; kind_bits = BitCntW'(9); job.header_long = 1'b1;
            job.term = 1'b1; job.gap_half_us = IdleDefHalf;
         end
         CMD_PACKET: begin
            job_valid = 1'b1; kind_bits = BitCntW'(9);
            job.gap_half_us = IdleDefHalf;
            sum_in = req.payload[7:0];
         end
         CMD_DATA: begin
            job_valid = 1'b1; kind_bits = BitCntW'(8);
            job.gap_half_us = IdleDefHalf;
            sum_in = sum_ff + req.payload[7:0];
         end
         CMD_CSUM: begin
            job_valid = 1'b1; kind_bits = BitCntW'(9);
            job.term = 1'b1; job.gap_half_us = IdleCsumHalf;
            job.word = {1'b0, sum_ff} | CsumFlag;
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
      if (int'(kind_bits) > MAX_DATA_BITS)
         job.nbits = BitCntW'(MAX_DATA_BITS);
      else
         job.nbits = kind_bits;
      job_valid = job_valid & accept;
   end

   always_ff @(posedge clock) begin
      if (reset)
         sum_ff <= '0;
      else if (accept)
         sum_ff <= sum_in;
   end

endmodule

// File: hw/rtl/irpwe_queue.sv
module irpwe_queue
   import irpwe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    full,
   output logic    empty,
   input  logic    rd_en,
   output job_type rd_job
);

   localparam int PtrW = $clog2(QueueDepth);

   job_type         slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   count_ff;

   assign full   = (count_ff == (PtrW+1)'(QueueDepth));
   assign empty  = (count_ff == '0);
   assign rd_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en)
         slot_ff[wr_ptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en)
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_ff + 1'b1;
         if (rd_en)
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_ff + 1'b1;
         if (wr_en && !rd_en)
            count_ff <= count_ff + 1'b1;
         else if (rd_en && !wr_en)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: hw/rtl/irpwe_back.sv
module irpwe_back
   import irpwe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_head,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp
);

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [BitCntW-1:0] bit_ff, bit_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;
   logic [3:0]         bit_idx;

   assign slot_free = !rsp_valid_ff || pop;
   assign empty     = !rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign bit_idx   = 4'(bit_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_head;
               state_in = ST_PRESYNC;
            end
         end
         ST_PRESYNC: begin
            if (slot_free) begin
               rsp_in       = '{1'b1, PresyncOnUs, PresyncOffUs, 1'b0};
               rsp_valid_in = 1'b1;
               state_in     = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (slot_free) begin
               rsp_in = '{1'b1, job_ff.header_long ? HdrLongUs : HdrShortUs,
                          GapOffUs, 1'b0};
               rsp_valid_in = 1'b1;
               bit_in       = job_ff.nbits;
               state_in     = ST_BITS;
            end
         end
         ST_BITS: begin
            if (slot_free) begin
               rsp_in = '{1'b1, job_ff.word[bit_idx] ? BitOneUs : BitZeroUs,
                          GapOffUs, 1'b0};
               rsp_valid_in = 1'b1;
               bit_in       = bit_ff - 1'b1;
               if (bit_ff == BitCntW'(1))
                  state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            if (slot_free) begin
               rsp_in = '{1'b0, job_ff.gap_half_us, job_ff.gap_half_us, !job_ff.term};
               rsp_valid_in = 1'b1;
               state_in     = job_ff.term ? ST_TERM : ST_IDLE;
            end
         end
         ST_TERM: begin
            if (slot_free) begin
               rsp_in       = '{1'b0, 16'd0, 16'd0, 1'b1};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_ff       <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: hw/rtl/ir_pulse_width_packet_encoder.sv
// Pulse-width IR packet encoder.
// Input side is a queue: drive req_data and push; the request transfers on
// a clock edge with push high and full low. Each request (command, payload)
// becomes a run of pulse pairs: pre-sync, header, one pair per data bit MSB
// first, idle gap, and for tag/beacon/checksum a zero terminator pair.
// Unknown commands are accepted and dropped. Packet loads and data adds to
// an 8-bit running checksum that a checksum request sends with bit 8 set.
// Result side is a queue: rsp_data is valid while empty is low and
// transfers on an edge with pop high.
// When idle, a transferred request is fetched into the sequencer's job
// register, then its first pair is registered onto rsp_data. A run has up to
// MAX_DATA_BITS + 4 pairs; the sequencer sends one pair per cycle while not
// stalled, then uses an idle state to fetch the next job from the 2-entry queue.
// When the receiver stalls, the pair held in the output register waits and
// the sequencer holds; the front keeps accepting until the queue fills.
// Reset (synchronous) clears the checksum, the queue and the output valid.
module ir_pulse_width_packet_encoder
   import irpwe_pkg::*;
#(
   parameter int MAX_DATA_BITS = DefMaxDataBits
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    job_valid;
   job_type job_new;
   logic    q_empty;
   logic    q_pop;
   job_type q_head;

   assign accept = push && !full;

   irpwe_front #(.MAX_DATA_BITS(MAX_DATA_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .job_valid (job_valid),
      .job       (job_new)
   );

   irpwe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_valid),
      .wr_job (job_new),
      .full   (full),
      .empty  (q_empty),
      .rd_en  (q_pop),
      .rd_job (q_head)
   );

   irpwe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job_head  (q_head),
      .job_pop   (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp_data)
   );

endmodule

// File: hw/rtl/irpwe_checker.sv
module irpwe_checker
   import irpwe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result offered right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled result changed");

   // final pair of a run is always an idle pair
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last_item) |-> !rsp_data.mark_level)
      else $error("last pair has carrier on");

   a_idle_even: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.mark_level) |-> (rsp_data.mark_us == rsp_data.space_us))
      else $error("idle pair halves differ");

   // a run always opens with the pre-sync pair
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_data.last_item) ##1 !empty |->
         (rsp_data.mark_level && rsp_data.mark_us == PresyncOnUs &&
          rsp_data.space_us == PresyncOffUs))
      else $error("run does not start with pre-sync");

endmodule

bind ir_pulse_width_packet_encoder irpwe_checker u_irpwe_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
